// ===== design/i2cmrs_pkg.sv =====
package i2cmrs_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned TailBytes = 3;
    localparam int unsigned MinReadLen = 4;

    typedef enum logic {
        OP_START = 1'b0,
        OP_EVENT = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_W_SB     = 4'd1,
        PH_W_ADDR   = 4'd2,
        PH_REG_BTF  = 4'd3,
        PH_DATA_BTF = 4'd4,
        PH_R_SB     = 4'd5,
        PH_R_ADDR   = 4'd6,
        PH_R_BULK   = 4'd7,
        PH_R_NACK   = 4'd8,
        PH_R_LAST2  = 4'd9,
        PH_R_RXNE   = 4'd10
    } t_phase;

    typedef struct packed {
        logic              gen_start;
        logic              gen_stop;
        logic              send_valid;
        logic [ByteW-1:0]  send_byte;
        logic              ack_on;
        logic              store_valid;
        logic [ByteW-1:0]  store_index;
        logic [ByteW-1:0]  store_byte;
        logic              done_res;
        logic              rejected;
        logic              busy_res;
    } t_result;

endpackage

// ===== design/i2c_master_register_access_sequencer_top.sv =====
// Channel   Handshake                     Payload
// input     i_in_valid / o_in_stall       i_opcode .. i_rx_byte
// output    o_out_valid / i_out_stall     o_gen_start .. o_busy_res
//
// One item is accepted per cycle while o_in_stall is low; its result is registered
// in the output register, or in the skid register while a result is stalled. The
// phase and transaction registers are updated in the same cycle the item is accepted.
// A skid register behind the output register keeps the input open for one
// more item while a result is stalled; o_in_stall rises only when it is full.
// Reset is synchronous and clears the phase, counters and valid flags.
module i2c_master_register_access_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic       i_is_read,
    input  logic [7:0] i_slave_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_byte_in,
    input  logic [7:0] i_read_len,
    input  logic       i_flag_sb,
    input  logic       i_flag_addr,
    input  logic       i_flag_btf,
    input  logic       i_flag_tra,
    input  logic       i_flag_rxne,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_gen_start,
    output logic       o_gen_stop,
    output logic       o_send_valid,
    output logic [7:0] o_send_byte,
    output logic       o_ack_on,
    output logic       o_store_valid,
    output logic [7:0] o_store_index,
    output logic [7:0] o_store_byte,
    output logic       o_done_res,
    output logic       o_rejected,
    output logic       o_busy_res
);

    localparam int unsigned W = i2cmrs_pkg::ByteW;

    i2cmrs_pkg::t_phase r_phase, n_phase;
    logic [W-1:0] r_byte_count, n_byte_count;
    logic [W-1:0] r_target_addr, n_target_addr;
    logic [W-1:0] r_register_addr, n_register_addr;
    logic [W-1:0] r_write_byte, n_write_byte;
    logic [W-1:0] r_read_length, n_read_length;
    logic         r_read_mode, n_read_mode;
    logic         r_ack_level, n_ack_level;

    i2cmrs_pkg::t_result w_res;
    i2cmrs_pkg::t_result r_out, r_skid;
    logic                r_out_valid, r_skid_valid;

    logic         w_in_fire, w_out_fire, w_out_free;
    logic         w_start_ok;
    logic [W:0]   w_count_inc;
    logic         w_bulk_end;

    assign w_in_fire  = i_in_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || w_out_fire;
    assign o_in_stall = r_skid_valid;

    assign w_start_ok = (r_phase == i2cmrs_pkg::PH_IDLE) &&
                        !(i_is_read && (i_read_len < W'(i2cmrs_pkg::MinReadLen)));
    assign w_count_inc = {1'b0, r_byte_count} + (W+1)'(1);
    // Bulk phase ends once the bytes taken plus the tail reach the length.
    assign w_bulk_end = (w_count_inc + (W+1)'(i2cmrs_pkg::TailBytes)) >=
                        {1'b0, r_read_length};

    // Next state of the phase machine and the transaction registers.
    always_comb begin
        n_phase         = r_phase;
        n_byte_count    = r_byte_count;
        n_target_addr   = r_target_addr;
        n_register_addr = r_register_addr;
        n_write_byte    = r_write_byte;
        n_read_length   = r_read_length;
        n_read_mode     = r_read_mode;
        n_ack_level     = r_ack_level;
        if (i_opcode == i2cmrs_pkg::OP_START) begin
            if (w_start_ok) begin
                n_read_mode     = i_is_read;
                n_target_addr   = i_slave_addr;
                n_register_addr = i_reg_addr;
                n_write_byte    = i_write_byte_in;
                n_read_length   = i_read_len;
                n_byte_count    = '0;
                n_phase         = i2cmrs_pkg::PH_W_SB;
            end
        end else begin
            unique case (r_phase)
                i2cmrs_pkg::PH_IDLE: begin
                end
                i2cmrs_pkg::PH_W_SB: begin
                    if (i_flag_sb) n_phase = i2cmrs_pkg::PH_W_ADDR;
                end
                i2cmrs_pkg::PH_W_ADDR: begin
                    if (i_flag_addr && i_flag_tra) n_phase = i2cmrs_pkg::PH_REG_BTF;
                end
                i2cmrs_pkg::PH_REG_BTF: begin
                    if (i_flag_btf) begin
                        n_phase = r_read_mode ? i2cmrs_pkg::PH_R_SB
                                              : i2cmrs_pkg::PH_DATA_BTF;
                    end
                end
                i2cmrs_pkg::PH_DATA_BTF: begin
                    if (i_flag_btf) n_phase = i2cmrs_pkg::PH_IDLE;
                end
                i2cmrs_pkg::PH_R_SB: begin
                    if (i_flag_sb) n_phase = i2cmrs_pkg::PH_R_ADDR;
                end
                i2cmrs_pkg::PH_R_ADDR: begin
                    if (i_flag_addr && !i_flag_tra) n_phase = i2cmrs_pkg::PH_R_BULK;
                end
                i2cmrs_pkg::PH_R_BULK: begin
                    if (i_flag_btf) begin
                        if (w_bulk_end) begin
                            n_byte_count = '0;
                            n_phase      = i2cmrs_pkg::PH_R_NACK;
                        end else begin
                            n_byte_count = w_count_inc[W-1:0];
                        end
                    end
                end
                i2cmrs_pkg::PH_R_NACK: begin
                    if (i_flag_btf) begin
                        n_ack_level = 1'b0;
                        n_phase     = i2cmrs_pkg::PH_R_LAST2;
                    end
                end
                i2cmrs_pkg::PH_R_LAST2: begin
                    if (i_flag_btf) begin
                        n_ack_level = 1'b1;
                        n_phase     = i2cmrs_pkg::PH_R_RXNE;
                    end
                end
                i2cmrs_pkg::PH_R_RXNE: begin
                    if (i_flag_rxne) n_phase = i2cmrs_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = i2cmrs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result of the item, from the current state and the item's fields.
    always_comb begin
        w_res = '0;
        if (i_opcode == i2cmrs_pkg::OP_START) begin
            w_res.rejected  = !w_start_ok;
            w_res.gen_start = w_start_ok;
        end else begin
            unique case (r_phase)
                i2cmrs_pkg::PH_W_SB: begin
                    if (i_flag_sb) begin
                        w_res.send_valid = 1'b1;
                        w_res.send_byte  = {r_target_addr[W-1:1], 1'b0};
                    end
                end
                i2cmrs_pkg::PH_W_ADDR: begin
                    if (i_flag_addr && i_flag_tra) begin
                        w_res.send_valid = 1'b1;
                        w_res.send_byte  = r_register_addr;
                    end
                end
                i2cmrs_pkg::PH_REG_BTF: begin
                    if (i_flag_btf) begin
                        if (r_read_mode) begin
                            w_res.gen_start = 1'b1;
                        end else begin
                            w_res.send_valid = 1'b1;
                            w_res.send_byte  = r_write_byte;
                        end
                    end
                end
                i2cmrs_pkg::PH_DATA_BTF: begin
                    if (i_flag_btf) begin
                        w_res.gen_stop = 1'b1;
                        w_res.done_res = 1'b1;
                    end
                end
                i2cmrs_pkg::PH_R_SB: begin
                    if (i_flag_sb) begin
                        w_res.send_valid = 1'b1;
                        w_res.send_byte  = {r_target_addr[W-1:1], 1'b1};
                    end
                end
                i2cmrs_pkg::PH_R_BULK: begin
                    if (i_flag_btf) begin
                        w_res.store_valid = 1'b1;
                        w_res.store_index = r_byte_count;
                        w_res.store_byte  = i_rx_byte;
                    end
                end
                i2cmrs_pkg::PH_R_NACK: begin
                    if (i_flag_btf) begin
                        w_res.store_valid = 1'b1;
                        w_res.store_index = r_read_length - W'(i2cmrs_pkg::TailBytes);
                        w_res.store_byte  = i_rx_byte;
                    end
                end
                i2cmrs_pkg::PH_R_LAST2: begin
                    if (i_flag_btf) begin
                        w_res.gen_stop    = 1'b1;
                        w_res.store_valid = 1'b1;
                        w_res.store_index = r_read_length - W'(2);
                        w_res.store_byte  = i_rx_byte;
                    end
                end
                i2cmrs_pkg::PH_R_RXNE: begin
                    if (i_flag_rxne) begin
                        w_res.store_valid = 1'b1;
                        w_res.store_index = r_read_length - W'(1);
                        w_res.store_byte  = i_rx_byte;
                        w_res.done_res    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        w_res.ack_on   = n_ack_level;
        w_res.busy_res = (n_phase != i2cmrs_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= i2cmrs_pkg::PH_IDLE;
            r_byte_count    <= '0;
            r_target_addr   <= '0;
            r_register_addr <= '0;
            r_write_byte    <= '0;
            r_read_length   <= '0;
            r_read_mode     <= 1'b0;
            r_ack_level     <= 1'b1;
        end else if (w_in_fire) begin
            r_phase         <= n_phase;
            r_byte_count    <= n_byte_count;
            r_target_addr   <= n_target_addr;
            r_register_addr <= n_register_addr;
            r_write_byte    <= n_write_byte;
            r_read_length   <= n_read_length;
            r_read_mode     <= n_read_mode;
            r_ack_level     <= n_ack_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_in_fire;
            r_skid_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_in_fire) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_gen_start   = r_out.gen_start;
    assign o_gen_stop    = r_out.gen_stop;
    assign o_send_valid  = r_out.send_valid;
    assign o_send_byte   = r_out.send_byte;
    assign o_ack_on      = r_out.ack_on;
    assign o_store_valid = r_out.store_valid;
    assign o_store_index = r_out.store_index;
    assign o_store_byte  = r_out.store_byte;
    assign o_done_res    = r_out.done_res;
    assign o_rejected    = r_out.rejected;
    assign o_busy_res    = r_out.busy_res;

endmodule

// ===== design/i2cmrs_checker.sv =====
module i2cmrs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_gen_start,
    input logic       o_gen_stop,
    input logic       o_send_valid,
    input logic [7:0] o_send_byte,
    input logic       o_store_valid,
    input logic       o_done_res,
    input logic       o_rejected,
    input logic       o_busy_res
);

    // The input side only stalls while a result is held at the output.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_send_byte) && $stable(o_done_res)))
        else $error("stalled result changed");

    a_reject_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (!o_gen_start && !o_gen_stop))
        else $error("refused start drove the bus");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("transaction finished but still busy");

    a_send_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_send_valid && o_store_valid))
        else $error("send and store in the same item");

endmodule

bind i2c_master_register_access_sequencer_top i2cmrs_checker u_i2cmrs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_gen_start  (o_gen_start),
    .o_gen_stop   (o_gen_stop),
    .o_send_valid (o_send_valid),
    .o_send_byte  (o_send_byte),
    .o_store_valid(o_store_valid),
    .o_done_res   (o_done_res),
    .o_rejected   (o_rejected),
    .o_busy_res   (o_busy_res)
);

// ===== verif/i2c_master_register_access_sequencer_top_test.sv =====
module i2c_master_register_access_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        i2cmrs_pkg::t_opcode          opcode;
        logic                         is_read;
        logic [i2cmrs_pkg::ByteW-1:0] slave_addr;
        logic [i2cmrs_pkg::ByteW-1:0] reg_addr;
        logic [i2cmrs_pkg::ByteW-1:0] write_byte_in;
        logic [i2cmrs_pkg::ByteW-1:0] read_len;
        logic                         flag_sb;
        logic                         flag_addr;
        logic                         flag_btf;
        logic                         flag_tra;
        logic                         flag_rxne;
        logic [i2cmrs_pkg::ByteW-1:0] rx_byte;
    } t_bus_item;

    typedef struct {
        t_bus_item   item;
        int unsigned gap;
    } t_queued_item;

    typedef struct {
        i2cmrs_pkg::t_phase           phase;
        logic [i2cmrs_pkg::ByteW-1:0] byte_count;
        logic [i2cmrs_pkg::ByteW-1:0] target_addr;
        logic [i2cmrs_pkg::ByteW-1:0] register_addr;
        logic [i2cmrs_pkg::ByteW-1:0] write_byte;
        logic [i2cmrs_pkg::ByteW-1:0] read_length;
        logic                         read_mode;
        logic                         ack_level;
    } t_seq_state;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    t_bus_item  bus_item    = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_gen_start;
    logic       o_gen_stop;
    logic       o_send_valid;
    logic [7:0] o_send_byte;
    logic       o_ack_on;
    logic       o_store_valid;
    logic [7:0] o_store_index;
    logic [7:0] o_store_byte;
    logic       o_done_res;
    logic       o_rejected;
    logic       o_busy_res;

    t_queued_item        pending_items[$];
    i2cmrs_pkg::t_result expected_results[$];
    t_seq_state          plan_state;
    t_seq_state          track_state;
    t_queued_item        next_item;
    bit           item_taken = 1'b0;
    bit           have_item  = 1'b0;
    bit           hold_long  = 1'b0;
    int unsigned  gap_left     = 0;
    int unsigned  stall_left   = 0;
    int unsigned  run_left     = 0;
    int unsigned  results_seen = 0;
    int unsigned  error_count  = 0;

    i2c_master_register_access_sequencer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (bus_item.opcode),
        .i_is_read       (bus_item.is_read),
        .i_slave_addr    (bus_item.slave_addr),
        .i_reg_addr      (bus_item.reg_addr),
        .i_write_byte_in (bus_item.write_byte_in),
        .i_read_len      (bus_item.read_len),
        .i_flag_sb       (bus_item.flag_sb),
        .i_flag_addr     (bus_item.flag_addr),
        .i_flag_btf      (bus_item.flag_btf),
        .i_flag_tra      (bus_item.flag_tra),
        .i_flag_rxne     (bus_item.flag_rxne),
        .i_rx_byte       (bus_item.rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_gen_start     (o_gen_start),
        .o_gen_stop      (o_gen_stop),
        .o_send_valid    (o_send_valid),
        .o_send_byte     (o_send_byte),
        .o_ack_on        (o_ack_on),
        .o_store_valid   (o_store_valid),
        .o_store_index   (o_store_index),
        .o_store_byte    (o_store_byte),
        .o_done_res      (o_done_res),
        .o_rejected      (o_rejected),
        .o_busy_res      (o_busy_res)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_seq_state idle_state();
        t_seq_state s;
        s.phase         = i2cmrs_pkg::PH_IDLE;
        s.byte_count    = '0;
        s.target_addr   = '0;
        s.register_addr = '0;
        s.write_byte    = '0;
        s.read_length   = '0;
        s.read_mode     = 1'b0;
        s.ack_level     = 1'b1;
        return s;
    endfunction

    // Advances the transaction state by one item and returns the result it produces.
    function automatic i2cmrs_pkg::t_result step_sequencer(inout t_seq_state st,
                                                           input t_bus_item it);
        i2cmrs_pkg::t_result r;
        r = '0;
        if (it.opcode == i2cmrs_pkg::OP_START) begin
            if (st.phase != i2cmrs_pkg::PH_IDLE ||
                (it.is_read && it.read_len < i2cmrs_pkg::MinReadLen)) begin
                r.rejected = 1'b1;
            end else begin
                st.read_mode     = it.is_read;
                st.target_addr   = it.slave_addr;
                st.register_addr = it.reg_addr;
                st.write_byte    = it.write_byte_in;
                st.read_length   = it.read_len;
                st.byte_count    = '0;
                st.phase         = i2cmrs_pkg::PH_W_SB;
                r.gen_start      = 1'b1;
            end
        end else begin
            case (st.phase)
                i2cmrs_pkg::PH_IDLE: begin
                end
                i2cmrs_pkg::PH_W_SB: begin
                    if (it.flag_sb) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = {st.target_addr[7:1], 1'b0};
                        st.phase     = i2cmrs_pkg::PH_W_ADDR;
                    end
                end
                i2cmrs_pkg::PH_W_ADDR: begin
                    if (it.flag_addr && it.flag_tra) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = st.register_addr;
                        st.phase     = i2cmrs_pkg::PH_REG_BTF;
                    end
                end
                i2cmrs_pkg::PH_REG_BTF: begin
                    if (it.flag_btf) begin
                        if (!st.read_mode) begin
                            r.send_valid = 1'b1;
                            r.send_byte  = st.write_byte;
                            st.phase     = i2cmrs_pkg::PH_DATA_BTF;
                        end else begin
                            r.gen_start = 1'b1;
                            st.phase    = i2cmrs_pkg::PH_R_SB;
                        end
                    end
                end
                i2cmrs_pkg::PH_DATA_BTF: begin
                    if (it.flag_btf) begin
                        r.gen_stop = 1'b1;
                        r.done_res = 1'b1;
                        st.phase   = i2cmrs_pkg::PH_IDLE;
                    end
                end
                i2cmrs_pkg::PH_R_SB: begin
                    if (it.flag_sb) begin
                        r.send_valid = 1'b1;
                        r.send_byte  = {st.target_addr[7:1], 1'b1};
                        st.phase     = i2cmrs_pkg::PH_R_ADDR;
                    end
                end
                i2cmrs_pkg::PH_R_ADDR: begin
                    if (it.flag_addr && !it.flag_tra) st.phase = i2cmrs_pkg::PH_R_BULK;
                end
                i2cmrs_pkg::PH_R_BULK: begin
                    if (it.flag_btf) begin
                        r.store_valid = 1'b1;
                        r.store_index = st.byte_count;
                        r.store_byte  = it.rx_byte;
                        st.byte_count = st.byte_count + 8'd1;
                        // The last three bytes are handled by the tail phases.
                        if (int'(st.byte_count) + int'(i2cmrs_pkg::TailBytes) >=
                            int'(st.read_length)) begin
                            st.byte_count = '0;
                            st.phase      = i2cmrs_pkg::PH_R_NACK;
                        end
                    end
                end
                i2cmrs_pkg::PH_R_NACK: begin
                    if (it.flag_btf) begin
                        st.ack_level  = 1'b0;
                        r.store_valid = 1'b1;
                        r.store_index = st.read_length - 8'(i2cmrs_pkg::TailBytes);
                        r.store_byte  = it.rx_byte;
                        st.phase      = i2cmrs_pkg::PH_R_LAST2;
                    end
                end
                i2cmrs_pkg::PH_R_LAST2: begin
                    if (it.flag_btf) begin
                        st.ack_level  = 1'b1;
                        r.gen_stop    = 1'b1;
                        r.store_valid = 1'b1;
                        r.store_index = st.read_length - 8'd2;
                        r.store_byte  = it.rx_byte;
                        st.phase      = i2cmrs_pkg::PH_R_RXNE;
                    end
                end
                i2cmrs_pkg::PH_R_RXNE: begin
                    if (it.flag_rxne) begin
                        r.store_valid = 1'b1;
                        r.store_index = st.read_length - 8'd1;
                        r.store_byte  = it.rx_byte;
                        r.done_res    = 1'b1;
                        st.phase      = i2cmrs_pkg::PH_IDLE;
                    end
                end
                default: begin
                    st.phase = i2cmrs_pkg::PH_IDLE;
                end
            endcase
        end
        r.ack_on   = st.ack_level;
        r.busy_res = (st.phase != i2cmrs_pkg::PH_IDLE);
        return r;
    endfunction

    function automatic t_bus_item rand_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return t_bus_item'(raw[$bits(t_bus_item)-1:0]);
    endfunction

    function automatic string result_diff(i2cmrs_pkg::t_result want,
                                          i2cmrs_pkg::t_result got);
        string d = "";
        if (want.gen_start !== got.gen_start)     d = {d, " gen_start"};
        if (want.gen_stop !== got.gen_stop)       d = {d, " gen_stop"};
        if (want.send_valid !== got.send_valid)   d = {d, " send_valid"};
        if (want.send_byte !== got.send_byte)     d = {d, " send_byte"};
        if (want.ack_on !== got.ack_on)           d = {d, " ack_on"};
        if (want.store_valid !== got.store_valid) d = {d, " store_valid"};
        if (want.store_index !== got.store_index) d = {d, " store_index"};
        if (want.store_byte !== got.store_byte)   d = {d, " store_byte"};
        if (want.done_res !== got.done_res)       d = {d, " done_res"};
        if (want.rejected !== got.rejected)       d = {d, " rejected"};
        if (want.busy_res !== got.busy_res)       d = {d, " busy_res"};
        return d;
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", msg);
    endtask

    // The planning copy of the state lets the stimulus follow the transaction it builds.
    task automatic add_item(t_bus_item it, int unsigned gap);
        pending_items.push_back('{item: it, gap: gap});
        void'(step_sequencer(plan_state, it));
    endtask

    task automatic add_start(logic rd, logic [7:0] sa, logic [7:0] ra, logic [7:0] wb,
                             logic [7:0] len);
        t_bus_item it;
        it               = '0;
        it.opcode        = i2cmrs_pkg::OP_START;
        it.is_read       = rd;
        it.slave_addr    = sa;
        it.reg_addr      = ra;
        it.write_byte_in = wb;
        it.read_len      = len;
        add_item(it, 0);
    endtask

    task automatic add_event(logic sb, logic ad, logic btf, logic tra, logic rxne,
                             logic [7:0] rx);
        t_bus_item it;
        it           = '0;
        it.opcode    = i2cmrs_pkg::OP_EVENT;
        it.flag_sb   = sb;
        it.flag_addr = ad;
        it.flag_btf  = btf;
        it.flag_tra  = tra;
        it.flag_rxne = rxne;
        it.rx_byte   = rx;
        add_item(it, 0);
    endtask

    // Sender: offers the queued items, honoring the idle gap stored with each one.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || item_taken)) begin
            item_taken = 1'b0;
            if (!have_item && pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                have_item = 1'b1;
                gap_left  = next_item.gap;
            end
            if (have_item && gap_left == 0) begin
                bus_item   <= next_item.item;
                i_in_valid <= 1'b1;
                have_item  = 1'b0;
            end else begin
                if (gap_left != 0) gap_left--;
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(step_sequencer(track_state, bus_item));
            item_taken = 1'b1;
        end
    end

    // Receiver: random stalls, with a calm window every so often.
    always @(negedge i_clk) begin
        if (hold_long) begin
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (run_left != 0) begin
            run_left--;
            i_out_stall <= 1'b0;
        end else begin
            run_left = $urandom_range(1, 12);
            if ((results_seen / 150) % 4 == 3) begin
                stall_left = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(12, 40);
            end else begin
                stall_left = $urandom_range(0, 3);
            end
            i_out_stall <= 1'b0;
        end
    end

    // One long hold-off so the output side fills up and the input stalls.
    initial begin
        wait (results_seen >= 400);
        @(posedge i_clk);
        hold_long = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_long = 1'b0;
    end

    always @(posedge i_clk) begin
        i2cmrs_pkg::t_result got;
        i2cmrs_pkg::t_result want;
        string               diff;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{gen_start: o_gen_start, gen_stop: o_gen_stop, send_valid: o_send_valid,
                    send_byte: o_send_byte, ack_on: o_ack_on, store_valid: o_store_valid,
                    store_index: o_store_index, store_byte: o_store_byte,
                    done_res: o_done_res, rejected: o_rejected, busy_res: o_busy_res};
            results_seen++;
            if (expected_results.size() == 0) begin
                note_error($sformatf("result %0d arrived with none expected: %p",
                                     results_seen, got));
            end else begin
                want = expected_results.pop_front();
                diff = result_diff(want, got);
                if (diff != "") begin
                    note_error($sformatf("result %0d differs in%s: expected %p, got %p",
                                         results_seen, diff, want, got));
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_bus_item   it;
        int unsigned roll;
        int unsigned size_roll;
        int unsigned gap;
        bit          good;
        bit          want_tra;
        bit          long_read_done;

        plan_state     = idle_state();
        track_state    = idle_state();
        long_read_done = 1'b0;

        // Directed: idle event, short reads rejected, a full write with a start
        // while busy and bad flags, then a minimum-length read, also with bad flags.
        add_event(1, 1, 1, 1, 1, 8'hFF);
        add_start(1, 8'hFF, 8'hFF, 8'hFF, 8'd3);
        add_start(1, 8'h00, 8'h00, 8'h00, 8'd0);
        add_start(0, 8'hFF, 8'h00, 8'hFF, 8'd0);
        add_start(0, 8'h12, 8'h34, 8'h56, 8'd9);
        add_event(0, 1, 1, 1, 1, 8'h00);
        add_event(1, 0, 0, 0, 0, 8'h00);
        add_event(0, 1, 0, 0, 0, 8'h00);
        add_event(0, 1, 0, 1, 0, 8'h00);
        add_event(0, 0, 1, 0, 0, 8'h00);
        add_event(0, 0, 1, 0, 0, 8'hFF);
        add_start(1, 8'h00, 8'hFF, 8'h00, 8'd4);
        add_event(1, 0, 0, 0, 0, 8'h00);
        add_event(0, 1, 0, 1, 0, 8'h00);
        add_event(0, 0, 1, 0, 0, 8'h00);
        add_event(1, 0, 0, 0, 0, 8'h00);
        add_event(0, 1, 0, 1, 0, 8'h00);
        add_event(0, 1, 0, 0, 0, 8'h00);
        add_event(0, 0, 1, 0, 0, 8'hA5);
        add_event(0, 0, 1, 0, 0, 8'h5A);
        add_event(0, 0, 1, 0, 0, 8'h00);
        add_event(1, 1, 1, 1, 0, 8'h11);
        add_event(0, 0, 0, 0, 1, 8'hFF);

        for (int n = 0; n < 1330; n++) begin
            it   = rand_item();
            roll = $urandom_range(0, 99);
            if (plan_state.phase == i2cmrs_pkg::PH_IDLE) begin
                if (roll < 8) begin
                    it.opcode = i2cmrs_pkg::OP_EVENT;
                end else begin
                    it.opcode = i2cmrs_pkg::OP_START;
                    if (roll < 15) begin
                        it.is_read  = 1'b1;
                        it.read_len = 8'($urandom_range(0, i2cmrs_pkg::MinReadLen - 1));
                    end else if (it.is_read) begin
                        size_roll = $urandom_range(0, 99);
                        if (!long_read_done) begin
                            it.read_len    = 8'd255;
                            long_read_done = 1'b1;
                        end else if (size_roll == 0) begin
                            it.read_len = 8'($urandom_range(i2cmrs_pkg::MinReadLen, 255));
                        end else if (size_roll < 6) begin
                            it.read_len = 8'($urandom_range(13, 40));
                        end else begin
                            it.read_len = 8'($urandom_range(i2cmrs_pkg::MinReadLen, 12));
                        end
                    end
                end
            end else if (roll < 6) begin
                it.opcode = i2cmrs_pkg::OP_START;
            end else begin
                // Mostly the flag the phase waits for; otherwise an event it must ignore.
                it.opcode = i2cmrs_pkg::OP_EVENT;
                good      = (roll >= 18);
                case (plan_state.phase)
                    i2cmrs_pkg::PH_W_SB, i2cmrs_pkg::PH_R_SB: it.flag_sb = good;
                    i2cmrs_pkg::PH_W_ADDR, i2cmrs_pkg::PH_R_ADDR: begin
                        want_tra = (plan_state.phase == i2cmrs_pkg::PH_W_ADDR);
                        if (good || $urandom_range(0, 1) == 1) begin
                            it.flag_addr = 1'b1;
                            it.flag_tra  = good ? want_tra : !want_tra;
                        end else begin
                            it.flag_addr = 1'b0;
                        end
                    end
                    i2cmrs_pkg::PH_R_RXNE: it.flag_rxne = good;
                    default: it.flag_btf = good;
                endcase
            end
            roll = $urandom_range(0, 99);
            if ((n / 100) % 3 == 2 || roll < 70) gap = 0;
            else if (roll < 95) gap = $urandom_range(1, 3);
            else gap = $urandom_range(10, 30);
            add_item(it, gap);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || have_item || i_in_valid ||
               expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/i2cmrs_pkg.sv
design/i2c_master_register_access_sequencer_top.sv
design/i2cmrs_checker.sv
verif/i2c_master_register_access_sequencer_top_test.sv
